// File: design/qvr_pkg.sv
package qvr_pkg;

  localparam int QUAT_WIDTH_DEF = 16;
  localparam int VEC_WIDTH_DEF  = 24;

  // integer bits of the fixed-point formats: Q2.14 and Q8.16 at default widths
  localparam int QUAT_INT_BITS = 2;
  localparam int VEC_INT_BITS  = 8;

endpackage

// File: design/qvr_if.sv
interface qvr_in_if #(
  parameter int QUAT_WIDTH = qvr_pkg::QUAT_WIDTH_DEF,
  parameter int VEC_WIDTH  = qvr_pkg::VEC_WIDTH_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [QUAT_WIDTH-1:0] quat_w;
  logic signed [QUAT_WIDTH-1:0] quat_i;
  logic signed [QUAT_WIDTH-1:0] quat_j;
  logic signed [QUAT_WIDTH-1:0] quat_k;
  logic signed [VEC_WIDTH-1:0]  vec_x;
  logic signed [VEC_WIDTH-1:0]  vec_y;
  logic signed [VEC_WIDTH-1:0]  vec_z;

  modport source (
    output valid, quat_w, quat_i, quat_j, quat_k, vec_x, vec_y, vec_z,
    input  ready
  );
  modport sink (
    input  valid, quat_w, quat_i, quat_j, quat_k, vec_x, vec_y, vec_z,
    output ready
  );
endinterface

interface qvr_out_if #(
  parameter int VEC_WIDTH = qvr_pkg::VEC_WIDTH_DEF
);
  logic                        valid;
  logic                        ready;
  logic signed [VEC_WIDTH-1:0] out_x;
  logic signed [VEC_WIDTH-1:0] out_y;
  logic signed [VEC_WIDTH-1:0] out_z;
  logic                        clipped;

  modport source (
    output valid, out_x, out_y, out_z, clipped,
    input  ready
  );
  modport sink (
    input  valid, out_x, out_y, out_z, clipped,
    output ready
  );
endinterface

// File: design/quaternion_vector_rotate_core.sv
// Rotates a vector by a quaternion: vector part of conj(q) * (0, v) * q.
// Five register stages: q*v products, first sums, p*q products, second sums,
// round and saturate.
// One item per cycle unless stalled; stalled stages hold, empty ones still fill.
// Reset (rst, synchronous) clears the stage valid bits only.
module quaternion_vector_rotate_core #(
  parameter int QUAT_WIDTH = qvr_pkg::QUAT_WIDTH_DEF,
  parameter int VEC_WIDTH  = qvr_pkg::VEC_WIDTH_DEF
) (
  input logic clk,
  input logic rst,
  qvr_in_if.sink    item,
  qvr_out_if.source result
);
  import qvr_pkg::*;

  localparam int QF = QUAT_WIDTH - QUAT_INT_BITS;
  localparam int FS = 2 * QF;
  localparam int MW = QUAT_WIDTH + VEC_WIDTH;   // q*v product
  localparam int PW = MW + 2;                   // sum of three products
  localparam int TW = PW + QUAT_WIDTH;          // p*q product
  localparam int AW = TW + 3;                   // four terms plus rounding half
  localparam int RW = AW - FS;                  // rounded value
  localparam int VF = VEC_WIDTH - VEC_INT_BITS;
  localparam int UW = RW - VEC_WIDTH + 1;       // bits that must agree to fit

  localparam logic signed [AW-1:0] HALF = AW'(1) <<< (FS - 1);
  localparam logic signed [VEC_WIDTH-1:0] MAXV = {1'b0, {(VEC_WIDTH-1){1'b1}}};
  localparam logic signed [VEC_WIDTH-1:0] MINV = {1'b1, {(VEC_WIDTH-1){1'b0}}};

  // index order: q = {w, i, j, k}, v = {x, y, z}
  logic signed [QUAT_WIDTH-1:0] q_in [4];
  logic signed [VEC_WIDTH-1:0]  v_in [3];

  logic v1, v2, v3, v4, v5;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;

  logic signed [MW-1:0]         qv  [4][3];
  logic signed [QUAT_WIDTH-1:0] q1  [4];
  logic signed [PW-1:0]         p   [4];
  logic signed [QUAT_WIDTH-1:0] q2  [4];
  logic signed [TW-1:0]         t   [3][4];
  logic signed [AW-1:0]         acc [3];
  logic signed [VEC_WIDTH-1:0]  res [3];
  logic                         clip;

  logic signed [RW-1:0]         rnd      [3];
  logic signed [VEC_WIDTH-1:0]  sat_next [3];
  logic [2:0]                   ovf;

  assign q_in[0] = item.quat_w;
  assign q_in[1] = item.quat_i;
  assign q_in[2] = item.quat_j;
  assign q_in[3] = item.quat_k;
  assign v_in[0] = item.vec_x;
  assign v_in[1] = item.vec_y;
  assign v_in[2] = item.vec_z;

  assign rdy5 = !v5 || result.ready;
  assign rdy4 = !v4 || rdy5;
  assign rdy3 = !v3 || rdy4;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;
  assign item.ready = rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (rdy1) v1 <= item.valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
      if (rdy5) v5 <= v4;
    end
  end

  // stage 1: q * v products
  always_ff @(posedge clk) begin
    if (rdy1 && item.valid) begin
      for (int a = 0; a < 4; a++) begin
        q1[a] <= q_in[a];
        for (int b = 0; b < 3; b++) begin
          qv[a][b] <= MW'(MW'(q_in[a]) * MW'(v_in[b]));
        end
      end
    end
  end

  // stage 2: p = conj(q) * (0, v)
  always_ff @(posedge clk) begin
    if (rdy2 && v1) begin
      p[0] <= PW'(qv[1][0]) + PW'(qv[2][1]) + PW'(qv[3][2]);
      p[1] <= PW'(qv[0][0]) - PW'(qv[2][2]) + PW'(qv[3][1]);
      p[2] <= PW'(qv[0][1]) + PW'(qv[1][2]) - PW'(qv[3][0]);
      p[3] <= PW'(qv[0][2]) - PW'(qv[1][1]) + PW'(qv[2][0]);
      q2   <= q1;
    end
  end

  // stage 3: p * q products, grouped by output axis
  always_ff @(posedge clk) begin
    if (rdy3 && v2) begin
      t[0][0] <= TW'(TW'(p[0]) * TW'(q2[1]));
      t[0][1] <= TW'(TW'(p[1]) * TW'(q2[0]));
      t[0][2] <= TW'(TW'(p[2]) * TW'(q2[3]));
      t[0][3] <= TW'(TW'(p[3]) * TW'(q2[2]));
      t[1][0] <= TW'(TW'(p[0]) * TW'(q2[2]));
      t[1][1] <= TW'(TW'(p[1]) * TW'(q2[3]));
      t[1][2] <= TW'(TW'(p[2]) * TW'(q2[0]));
      t[1][3] <= TW'(TW'(p[3]) * TW'(q2[1]));
      t[2][0] <= TW'(TW'(p[0]) * TW'(q2[3]));
      t[2][1] <= TW'(TW'(p[1]) * TW'(q2[2]));
      t[2][2] <= TW'(TW'(p[2]) * TW'(q2[1]));
      t[2][3] <= TW'(TW'(p[3]) * TW'(q2[0]));
    end
  end

  // stage 4: exact sums with the rounding half folded in
  always_ff @(posedge clk) begin
    if (rdy4 && v3) begin
      acc[0] <= AW'(t[0][0]) + AW'(t[0][1]) + AW'(t[0][2]) - AW'(t[0][3]) + HALF;
      acc[1] <= AW'(t[1][0]) - AW'(t[1][1]) + AW'(t[1][2]) + AW'(t[1][3]) + HALF;
      acc[2] <= AW'(t[2][0]) + AW'(t[2][1]) - AW'(t[2][2]) + AW'(t[2][3]) + HALF;
    end
  end

  // stage 5: shift down and saturate
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      rnd[c] = acc[c][AW-1:FS];
      ovf[c] = !((&rnd[c][RW-1:VEC_WIDTH-1]) || !(|rnd[c][RW-1:VEC_WIDTH-1]));
      if (ovf[c]) begin
        sat_next[c] = rnd[c][RW-1] ? MINV : MAXV;
      end else begin
        sat_next[c] = rnd[c][VEC_WIDTH-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy5 && v4) begin
      res  <= sat_next;
      clip <= |ovf;
    end
  end

  assign result.valid   = v5;
  assign result.out_x   = res[0];
  assign result.out_y   = res[1];
  assign result.out_z   = res[2];
  assign result.clipped = clip;

  // fraction bits of the vector format are carried implicitly
  if (VF < 1 || UW < 1) begin : g_bad_width
    $error("unsupported widths");
  end

endmodule

// File: dv/qvr_rotate_checker.sv
`timescale 1ns / 100ps

module qvr_rotate_checker (
  input  logic clk,
  input  logic rst,
  qvr_in_if    item,
  qvr_out_if   result,
  output int   errors,
  output int   pending
);
  import qvr_pkg::*;

  localparam int QW = QUAT_WIDTH_DEF;
  localparam int VW = VEC_WIDTH_DEF;
  localparam int ACC_W = 80;
  localparam int ROUND_SHIFT = 2 * (QW - QUAT_INT_BITS);
  localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (ROUND_SHIFT - 1);
  localparam logic signed [ACC_W-1:0] OUT_MAX = (ACC_W'(1) << (VW - 1)) - 1;
  localparam logic signed [ACC_W-1:0] OUT_MIN = -OUT_MAX - 1;

  typedef struct packed {
    logic signed [VW-1:0] x;
    logic signed [VW-1:0] y;
    logic signed [VW-1:0] z;
    logic                 clipped;
  } rotation_t;

  rotation_t rotation_q[$];
  int        err_cnt = 0;
  int        queued = 0;

  assign errors  = err_cnt;
  assign pending = queued;

  function automatic logic signed [VW-1:0] round_sat(input logic signed [ACC_W-1:0] acc,
                                                     inout logic clip);
    logic signed [ACC_W-1:0] r;
    r = (acc + ROUND_HALF) >>> ROUND_SHIFT;
    if (r > OUT_MAX) begin
      r = OUT_MAX;
      clip = 1'b1;
    end else if (r < OUT_MIN) begin
      r = OUT_MIN;
      clip = 1'b1;
    end
    return r[VW-1:0];
  endfunction

  // vector part of conj(q) * (0, v) * q, exact until the final rounding
  function automatic rotation_t rotate_vec(
    input logic signed [QW-1:0] w, input logic signed [QW-1:0] i,
    input logic signed [QW-1:0] j, input logic signed [QW-1:0] k,
    input logic signed [VW-1:0] x, input logic signed [VW-1:0] y,
    input logic signed [VW-1:0] z
  );
    logic signed [ACC_W-1:0] pw, pi, pj, pk, ax, ay, az;
    rotation_t res;
    logic clip;
    clip = 1'b0;
    pw = i * x + j * y + k * z;
    pi = w * x - j * z + k * y;
    pj = w * y + i * z - k * x;
    pk = w * z - i * y + j * x;
    ax = pw * i + pi * w + pj * k - pk * j;
    ay = pw * j - pi * k + pj * w + pk * i;
    az = pw * k + pi * j - pj * i + pk * w;
    res.x = round_sat(ax, clip);
    res.y = round_sat(ay, clip);
    res.z = round_sat(az, clip);
    res.clipped = clip;
    return res;
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      err_cnt++;
    end
  endtask

  always @(posedge clk) begin
    rotation_t want;
    if (rst) begin
      queued <= 0;
    end else begin
      if (result.valid && result.ready) begin
        if (rotation_q.size() == 0) begin
          $error("result transfer with no item outstanding");
          err_cnt++;
        end else begin
          want = rotation_q.pop_front();
          check_field("out_x", int'(want.x), int'(result.out_x));
          check_field("out_y", int'(want.y), int'(result.out_y));
          check_field("out_z", int'(want.z), int'(result.out_z));
          check_field("clipped", int'(want.clipped), int'(result.clipped));
        end
      end
      if (item.valid && item.ready)
        rotation_q.push_back(rotate_vec(item.quat_w, item.quat_i, item.quat_j, item.quat_k,
                                        item.vec_x, item.vec_y, item.vec_z));
      queued <= rotation_q.size();
    end
  end

endmodule

// File: dv/quaternion_vector_rotate_core_tb.sv
`timescale 1ns / 100ps

module quaternion_vector_rotate_core_tb;
  import qvr_pkg::*;

  localparam int QW = QUAT_WIDTH_DEF;
  localparam int VW = VEC_WIDTH_DEF;
  localparam int NUM_RANDOM = 1250;
  localparam logic [QW-1:0] Q_MIN = {1'b1, {(QW-1){1'b0}}};
  localparam logic [QW-1:0] Q_MAX = {1'b0, {(QW-1){1'b1}}};
  localparam logic [QW-1:0] Q_ONE = QW'(1) << (QW - QUAT_INT_BITS);
  localparam logic [QW-1:0] Q_HALF_SQRT2 = QW'(11585);
  localparam logic [VW-1:0] V_MIN = {1'b1, {(VW-1){1'b0}}};
  localparam logic [VW-1:0] V_MAX = {1'b0, {(VW-1){1'b1}}};
  localparam logic [VW-1:0] V_ONE = VW'(1) << (VW - VEC_INT_BITS);

  logic clk;
  logic rst;
  int   fail_count;
  int   pending_count;
  logic send_burst;
  logic recv_burst;

  qvr_in_if  #(.QUAT_WIDTH(QW), .VEC_WIDTH(VW)) item_ch ();
  qvr_out_if #(.VEC_WIDTH(VW))                  result_ch ();

  quaternion_vector_rotate_core #(
    .QUAT_WIDTH(QW),
    .VEC_WIDTH (VW)
  ) uut (
    .clk   (clk),
    .rst   (rst),
    .item  (item_ch),
    .result(result_ch)
  );

  qvr_rotate_checker chk (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch),
    .errors (fail_count),
    .pending(pending_count)
  );

  initial clk = 1'b0;
  always #5ns clk = ~clk;

  initial begin
    rst = 1'b1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
  end

  initial begin
    #5ms;
    $display("tb: failure");
    $finish;
  end

  function automatic int draw_gap(inout logic burst);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 15);
    if ($urandom_range(0, 49) == 0)
      burst = ~burst;
    return gap;
  endfunction

  function automatic logic [QW-1:0] corner_quat();
    case ($urandom_range(0, 4))
      0: return Q_MIN;
      1: return Q_MAX;
      2: return '0;
      3: return '1;
      default: return QW'(1);
    endcase
  endfunction

  function automatic logic [VW-1:0] corner_vec();
    case ($urandom_range(0, 4))
      0: return V_MIN;
      1: return V_MAX;
      2: return '0;
      3: return '1;
      default: return VW'(1);
    endcase
  endfunction

  task automatic send_rotation(input logic [QW-1:0] w, input logic [QW-1:0] i,
                               input logic [QW-1:0] j, input logic [QW-1:0] k,
                               input logic [VW-1:0] x, input logic [VW-1:0] y,
                               input logic [VW-1:0] z);
    int gap;
    gap = draw_gap(send_burst);
    if (gap > 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_ch.valid  <= 1'b1;
    item_ch.quat_w <= w;
    item_ch.quat_i <= i;
    item_ch.quat_j <= j;
    item_ch.quat_k <= k;
    item_ch.vec_x  <= x;
    item_ch.vec_y  <= y;
    item_ch.vec_z  <= z;
    do @(posedge clk); while (item_ch.ready !== 1'b1);
  endtask

  // hold the input idle until every outstanding result has come back
  task automatic drain();
    item_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
  endtask

  // result side: random backpressure
  initial begin
    int gap;
    recv_burst = 1'b0;
    result_ch.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      gap = draw_gap(recv_burst);
      if (gap > 0) begin
        result_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      result_ch.ready <= 1'b1;
      do @(posedge clk); while (result_ch.valid !== 1'b1);
    end
  end

  initial begin
    logic [QW-1:0] qw, qi, qj, qk;
    logic [VW-1:0] vx, vy, vz;
    int mode;
    send_burst = 1'b0;
    item_ch.valid  <= 1'b0;
    item_ch.quat_w <= '0;
    item_ch.quat_i <= '0;
    item_ch.quat_j <= '0;
    item_ch.quat_k <= '0;
    item_ch.vec_x  <= '0;
    item_ch.vec_y  <= '0;
    item_ch.vec_z  <= '0;
    do @(posedge clk); while (rst);

    send_rotation('0, '0, '0, '0, '0, '0, '0);
    send_rotation(Q_ONE, '0, '0, '0, V_MAX, V_MIN, '0);
    send_rotation(Q_ONE, '0, '0, '0, VW'(1), '1, V_MIN);
    // rounding ties at half an LSB, toward plus infinity
    send_rotation(QW'(128), '0, '0, '0, VW'(8192), '0, '0);
    send_rotation(QW'(128), '0, '0, '0, -VW'(8192), '0, '0);
    send_rotation('0, Q_ONE, '0, '0, V_ONE, VW'(2 * V_ONE), VW'(3 * V_ONE));
    send_rotation('0, '0, Q_ONE, '0, V_ONE, VW'(2 * V_ONE), VW'(3 * V_ONE));
    send_rotation('0, '0, '0, Q_ONE, V_ONE, VW'(2 * V_ONE), VW'(3 * V_ONE));
    send_rotation(Q_HALF_SQRT2, '0, '0, Q_HALF_SQRT2, V_ONE, '0, '0);
    send_rotation(Q_HALF_SQRT2, Q_HALF_SQRT2, '0, '0, '0, V_ONE, '0);
    send_rotation(Q_HALF_SQRT2, '0, Q_HALF_SQRT2, '0, '0, '0, V_ONE);
    send_rotation(Q_MIN, Q_MIN, Q_MIN, Q_MIN, V_MIN, V_MIN, V_MIN);
    send_rotation(Q_MAX, Q_MAX, Q_MAX, Q_MAX, V_MAX, V_MAX, V_MAX);
    send_rotation(Q_MIN, '0, '0, '0, V_MAX, V_MIN, V_MAX);
    send_rotation(Q_MAX, Q_MIN, Q_MAX, Q_MIN, V_MIN, V_MAX, V_MIN);
    send_rotation('1, '1, '1, '1, '1, '1, '1);
    send_rotation(QW'(1), QW'(1), QW'(1), QW'(1), VW'(1), VW'(1), VW'(1));
    send_rotation(Q_ONE, Q_ONE, Q_ONE, Q_ONE, V_ONE, -V_ONE, V_ONE);
    send_rotation(Q_ONE, -Q_ONE, Q_ONE, -Q_ONE, V_MAX, V_MAX, V_MIN);
    drain();

    for (int n = 0; n < NUM_RANDOM; n++) begin
      mode = $urandom_range(0, 9);
      if (mode < 5) begin
        qw = QW'($urandom);
        qi = QW'($urandom);
        qj = QW'($urandom);
        qk = QW'($urandom);
        vx = VW'($urandom);
        vy = VW'($urandom);
        vz = VW'($urandom);
      end else if (mode < 8) begin
        // roughly unit-sized quaternions, the normal use
        qw = QW'(int'($urandom_range(0, 32768)) - 16384);
        qi = QW'(int'($urandom_range(0, 32768)) - 16384);
        qj = QW'(int'($urandom_range(0, 32768)) - 16384);
        qk = QW'(int'($urandom_range(0, 32768)) - 16384);
        vx = VW'($urandom);
        vy = VW'($urandom);
        vz = VW'($urandom);
      end else if (mode < 9) begin
        qw = corner_quat();
        qi = corner_quat();
        qj = corner_quat();
        qk = corner_quat();
        vx = corner_vec();
        vy = corner_vec();
        vz = corner_vec();
      end else begin
        qw = QW'(int'($urandom_range(0, 16)) - 8);
        qi = QW'(int'($urandom_range(0, 16)) - 8);
        qj = QW'(int'($urandom_range(0, 16)) - 8);
        qk = QW'(int'($urandom_range(0, 16)) - 8);
        vx = VW'(int'($urandom_range(0, 1023)) - 512);
        vy = VW'(int'($urandom_range(0, 1023)) - 512);
        vz = VW'(int'($urandom_range(0, 1023)) - 512);
      end
      send_rotation(qw, qi, qj, qk, vx, vy, vz);
      if (n % 400 == 399)
        drain();
    end

    drain();
    repeat (10) @(posedge clk);
    if (fail_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

// File: filelist.f
design/qvr_pkg.sv
design/qvr_if.sv
design/quaternion_vector_rotate_core.sv
dv/qvr_rotate_checker.sv
dv/quaternion_vector_rotate_core_tb.sv
